// ----- rtl/multitap_feedback_reverb_core_assert.svh -----
// ============================================================================
// Assertion macros for the multitap feedback reverb core
// Shared concurrent property wrappers; every property is disabled in reset.
// ============================================================================
`ifndef MULTITAP_FEEDBACK_REVERB_CORE_ASSERT_SVH
`define MULTITAP_FEEDBACK_REVERB_CORE_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds
`define MFR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication: cons must hold in the cycle after ante
`define MFR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/mfr_pkg.sv -----
// ============================================================================
// mfr_pkg
// Shared constants, microcode control word and condition codes of the reverb.
// ============================================================================
`timescale 1ns / 1ps

package mfr_pkg;

    // Delay line geometry (power of two, addressed by the 15-bit delay field)
    localparam int LINE_DEPTH   = 32768;
    localparam int ADDR_W       = $clog2(LINE_DEPTH);
    localparam int TAP_COUNT    = 8;
    localparam int NUM_TAP_REGS = 8;

    // Field widths
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 3;
    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 16;
    localparam int DELAY_W   = 15;
    localparam int DELAY_LSB = 16;
    localparam int FRAC_W    = 15;
    localparam int PROD_W    = 2 * SAMPLE_W;
    localparam int ACC_W     = 35;
    localparam int RES_W     = ACC_W - FRAC_W;
    localparam int TAP_SEL_W = 3;

    // Sequencer
    localparam int STEP_W = 4;

    // Step condition codes
    typedef enum logic [1:0] {
        COND_ALWAYS = 2'd0,
        COND_IN     = 2'd1,
        COND_OUT    = 2'd2
    } cond_t;

    // One microcode control word
    typedef struct packed {
        cond_t                 cond;
        logic                  load_acc;
        logic                  rd_en;
        logic [TAP_SEL_W-1:0]  tap_sel;
        logic                  mul_en;
        logic                  acc_en;
        logic                  finish;
        logic [STEP_W-1:0]     next_step;
    } ctrl_word_t;

    // Handshake status seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic out_free;
    } seq_status_t;

    // Program step names
    localparam logic [STEP_W-1:0] STEP_WAIT   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_RD0    = 4'd1;
    localparam logic [STEP_W-1:0] STEP_DRAIN1 = 4'd9;
    localparam logic [STEP_W-1:0] STEP_DRAIN2 = 4'd10;
    localparam logic [STEP_W-1:0] STEP_DONE   = 4'd11;

endpackage

// ----- rtl/multitap_feedback_reverb_core.sv -----
// ============================================================================
// multitap_feedback_reverb_core
// Multitap feedback delay reverb: eight gain-scaled taps of past output.
// ============================================================================
// Usage:
//   Input channel s_valid/s_ready carries one signed Q1.15 word per sample in
//   s_sample_in. Result channel m_valid/m_ready returns the saturated sum in
//   m_sample_out with m_clipped set when saturation took place.
//   Taps are set through cfg_we/cfg_index/cfg_wdata (gain in bits 15:0,
//   delay in bits 30:16, delay zero turns the tap off); write them only
//   while no word is in flight.
//   After acceptance each word runs through eight tap reads from the single
//   delay line port, with the multiplier and then the accumulator working
//   behind the reads, two drain steps, and one write-back step.
//   A new word is accepted only after the previous one has been written back.
//   A result waits in the output register while m_ready is low; the block
//   accepts and processes the next word meanwhile, holding only its
//   write-back step until the register is free.
//   Reset clears the tap registers, the write pointer and the output valid.
//   The delay line needs no clearing pass: a fill flag makes entries not
//   yet written since reset read as silence.
// ============================================================================
`timescale 1ns / 1ps

`include "multitap_feedback_reverb_core_assert.svh"

module multitap_feedback_reverb_core
    import mfr_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample_in,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_sample_out,
    output logic                       m_clipped,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_wdata
);

    logic [CFG_W-1:0]           tap_words_reg [NUM_TAP_REGS];
    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] m_sample_out_reg;
    logic                       m_clipped_reg;

    seq_status_t                status;
    ctrl_word_t                 cw;
    logic                       go;
    logic signed [SAMPLE_W-1:0] res_sample;
    logic                       res_clip;
    logic                       out_load;

    assign status.in_valid = s_valid;
    assign status.out_free = !m_valid_reg || m_ready;
    assign s_ready         = (cw.cond == COND_IN);
    assign out_load        = cw.finish && go;

    mfr_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .cw      (cw),
        .go      (go)
    );

    mfr_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cw         (cw),
        .go         (go),
        .sample_in  (s_sample_in),
        .tap_words  (tap_words_reg),
        .res_sample (res_sample),
        .res_clip   (res_clip)
    );

    // Tap configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_TAP_REGS; i++) begin
                tap_words_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            tap_words_reg[cfg_index] <= cfg_wdata;
        end
    end

    // Output register: load on write-back, drop on handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_sample_out_reg <= res_sample;
            m_clipped_reg    <= res_clip;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_out_reg;
    assign m_clipped    = m_clipped_reg;

    // A word in flight blocks the next until write-back
    `MFR_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    // Write-back never overlaps an accept step
    `MFR_ASSERT_IMP(a_no_load_while_ready, aclk, aresetn, s_ready, !out_load)
    // Write-back always leaves a valid result
    `MFR_ASSERT_NXT(a_load_sets_valid, aclk, aresetn, out_load, m_valid)

endmodule

// ----- rtl/mfr_ucode_rom.sv -----
// ============================================================================
// mfr_ucode_rom
// Read-only program of the reverb sequencer: one control word per step.
// ============================================================================
`timescale 1ns / 1ps

module mfr_ucode_rom
    import mfr_pkg::*;
(
    input  logic [STEP_W-1:0] step,
    output ctrl_word_t        cw
);

    // Decode the step into its control word
    always_comb begin
        cw = '0;
        cw.cond      = COND_ALWAYS;
        cw.next_step = STEP_WAIT;
        case (step)
            STEP_WAIT: begin
                cw.cond      = COND_IN;
                cw.load_acc  = 1'b1;
                cw.next_step = STEP_RD0;
            end
            4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8: begin
                // issue tap read, multiply previous tap, add the one before
                cw.rd_en     = 1'b1;
                cw.tap_sel   = TAP_SEL_W'(step - STEP_RD0);
                cw.mul_en    = (step != STEP_RD0);
                cw.acc_en    = (step > 4'd2);
                cw.next_step = step + 4'd1;
            end
            STEP_DRAIN1: begin
                cw.mul_en    = 1'b1;
                cw.acc_en    = 1'b1;
                cw.next_step = STEP_DRAIN2;
            end
            STEP_DRAIN2: begin
                cw.acc_en    = 1'b1;
                cw.next_step = STEP_DONE;
            end
            STEP_DONE: begin
                cw.cond      = COND_OUT;
                cw.finish    = 1'b1;
                cw.next_step = STEP_WAIT;
            end
            default: begin
                cw.next_step = STEP_WAIT;
            end
        endcase
    end

endmodule

// ----- rtl/mfr_seq.sv -----
// ============================================================================
// mfr_seq
// Step counter: advances through the program, holding on unmet conditions.
// ============================================================================
`timescale 1ns / 1ps

module mfr_seq
    import mfr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  seq_status_t status,
    output ctrl_word_t  cw,
    output logic        go
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    mfr_ucode_rom u_rom (
        .step (step_reg),
        .cw   (cw)
    );

    // Evaluate the step's condition
    always_comb begin
        case (cw.cond)
            COND_ALWAYS: go = 1'b1;
            COND_IN:     go = status.in_valid;
            COND_OUT:    go = status.out_free;
            default:     go = 1'b1;
        endcase
        step_next = go ? cw.next_step : step_reg;
    end

    // Hold or advance the step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_WAIT;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

// ----- rtl/mfr_datapath.sv -----
// ============================================================================
// mfr_datapath
// Delay line memory, tap address generation, multiply-accumulate, saturation.
// ============================================================================
`timescale 1ns / 1ps

module mfr_datapath
    import mfr_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  ctrl_word_t                 cw,
    input  logic                       go,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic [CFG_W-1:0]           tap_words [NUM_TAP_REGS],
    output logic signed [SAMPLE_W-1:0] res_sample,
    output logic                       res_clip
);

    logic [SAMPLE_W-1:0] line_mem [LINE_DEPTH];

    logic [ADDR_W-1:0]          wp_reg;
    logic                       wrapped_reg;
    logic signed [SAMPLE_W-1:0] mem_q_reg;
    logic signed [GAIN_W-1:0]   gain_reg;
    logic                       tap_live_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;

    logic [CFG_W-1:0]         tap_word;
    logic [DELAY_W-1:0]       tap_delay;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     entry_filled;
    logic                     tap_on;
    logic signed [RES_W-1:0]  res_full;
    logic                     do_write;

    // Tap address: delay samples behind the write pointer
    always_comb begin
        tap_word     = tap_words[cw.tap_sel];
        tap_delay    = tap_word[DELAY_LSB +: DELAY_W];
        rd_addr      = wp_reg - ADDR_W'(tap_delay);
        entry_filled = wrapped_reg || (rd_addr < wp_reg);
        tap_on       = (tap_delay != '0) && ({1'b0, cw.tap_sel} < (TAP_SEL_W + 1)'(TAP_COUNT));
        do_write     = cw.finish && go;
    end

    // Drop the fractional bits and saturate
    always_comb begin
        res_full = acc_reg[ACC_W-1:FRAC_W];
        if (res_full > RES_W'(signed'(17'sd32767))) begin
            res_sample = 16'sh7FFF;
            res_clip   = 1'b1;
        end else if (res_full < RES_W'(signed'(17'sh18000))) begin
            res_sample = 16'sh8000;
            res_clip   = 1'b1;
        end else begin
            res_sample = res_full[SAMPLE_W-1:0];
            res_clip   = 1'b0;
        end
    end

    // Delay line: registered read, write of the finished sample
    always_ff @(posedge aclk) begin
        if (cw.rd_en) begin
            mem_q_reg <= line_mem[rd_addr];
        end
        if (do_write) begin
            line_mem[wp_reg] <= res_sample;
        end
    end

    // Advance the write pointer; remember the first full pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
        end else if (do_write) begin
            wp_reg <= wp_reg + 1'b1;
            if (wp_reg == {ADDR_W{1'b1}}) begin
                wrapped_reg <= 1'b1;
            end
        end
    end

    // Multiply-accumulate pipeline
    always_ff @(posedge aclk) begin
        if (cw.rd_en) begin
            gain_reg     <= tap_word[GAIN_W-1:0];
            tap_live_reg <= tap_on && entry_filled;
        end
        if (cw.mul_en) begin
            if (tap_live_reg) begin
                prod_reg <= mem_q_reg * gain_reg;
            end else begin
                prod_reg <= '0;
            end
        end
        if (cw.load_acc && go) begin
            acc_reg <= ACC_W'(sample_in) <<< FRAC_W;
        end else if (cw.acc_en) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

endmodule

// ----- sim/reverb_checker.sv -----
// ============================================================================
// reverb_checker
// Watches the sample and result channels and the tap write port of the
// reverb core. It keeps its own tap registers, delay line and write pointer,
// predicts each result word and compares it with the word the core returns.
// ============================================================================
`timescale 1ns / 1ps

module reverb_checker
    import mfr_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample_in,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic signed [SAMPLE_W-1:0] m_sample_out,
    input  logic                       m_clipped,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_wdata,
    output int                         mismatches,
    output int                         words_pending
);

    localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint SAT_LO = -(longint'(1) <<< (SAMPLE_W - 1));

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       clip;
    } reverb_word_t;

    logic [CFG_W-1:0]    tap_reg  [NUM_TAP_REGS];
    logic [SAMPLE_W-1:0] echo_mem [LINE_DEPTH];
    logic [ADDR_W-1:0]   head_ptr;
    reverb_word_t        reverb_out_q [$];
    int                  fault_cnt = 0;

    // Mix the dry sample with every enabled echo, saturate, and store the
    // result in the line before advancing the write pointer
    function automatic reverb_word_t reverb_step(logic signed [SAMPLE_W-1:0] dry);
        reverb_word_t       word;
        longint             acc;
        longint             res;
        logic [DELAY_W-1:0] dly;
        logic [ADDR_W-1:0]  rd_addr;
        acc = longint'(dry) <<< FRAC_W;
        for (int t = 0; t < TAP_COUNT; t++) begin
            dly = tap_reg[t][DELAY_LSB +: DELAY_W];
            // zero delay turns the tap off
            if (dly != '0) begin
                rd_addr = head_ptr - dly;
                acc += longint'($signed(echo_mem[rd_addr])) *
                       longint'($signed(tap_reg[t][GAIN_W-1:0]));
            end
        end
        // drop the fraction (floor), then clamp to the sample range
        res = acc >>> FRAC_W;
        word.clip = 1'b1;
        if (res > SAT_HI) begin
            res = SAT_HI;
        end else if (res < SAT_LO) begin
            res = SAT_LO;
        end else begin
            word.clip = 1'b0;
        end
        word.sample = SAMPLE_W'(res);
        echo_mem[head_ptr] = word.sample;
        head_ptr = head_ptr + 1'b1;
        return word;
    endfunction

    always @(posedge aclk) begin
        reverb_word_t got;
        reverb_word_t want;
        if (!aresetn) begin
            foreach (tap_reg[i]) tap_reg[i] = '0;
            foreach (echo_mem[i]) echo_mem[i] = '0;
            head_ptr = '0;
            reverb_out_q.delete();
        end else begin
            // track tap writes
            if (cfg_we && cfg_index < NUM_TAP_REGS) begin
                tap_reg[cfg_index] = cfg_wdata;
            end
            // compare a returned word with the oldest prediction
            if (m_valid && m_ready) begin
                got.sample = m_sample_out;
                got.clip   = m_clipped;
                if (reverb_out_q.size() == 0) begin
                    fault_cnt++;
                    if (fault_cnt <= 10) begin
                        $display("[%0t] unexpected result word: sample_out %0d clipped %0b",
                                 $time, got.sample, got.clip);
                    end
                end else begin
                    want = reverb_out_q.pop_front();
                    if (got.sample !== want.sample || got.clip !== want.clip) begin
                        fault_cnt++;
                        if (fault_cnt <= 10) begin
                            $display("[%0t] sample_out exp %0d got %0d, clipped exp %0b got %0b",
                                     $time, want.sample, got.sample, want.clip, got.clip);
                        end
                    end
                end
            end
            // predict the word for each accepted sample
            if (s_valid && s_ready) begin
                reverb_out_q.push_back(reverb_step(s_sample_in));
            end
        end
        words_pending <= reverb_out_q.size();
        mismatches    <= fault_cnt;
    end

endmodule

// ----- sim/tb.sv -----
// ============================================================================
// tb
// Drives the reverb core with directed and random samples under changing
// tap settings and handshake pressure; a checker beside the core predicts
// and compares every result word.
// ============================================================================
`timescale 1ns / 1ps

module tb;
    import mfr_pkg::*;

    localparam int WORD_LATENCY = 12;
    localparam int STALL_LIMIT  = 2000;
    localparam int SEG_WORDS    = 160;
    localparam int SEG_COUNT    = 6;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic [GAIN_W-1:0]          GAIN_POS1  = 16'h7FFF;
    localparam logic [GAIN_W-1:0]          GAIN_NEG1  = 16'h8000;
    localparam logic [DELAY_W-1:0]         DELAY_MAX  = '1;

    typedef enum int {
        TAPS_DIRECTED,
        TAPS_TYPICAL,
        TAPS_EXTREME
    } tap_plan_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample_in;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] m_sample_out;
    logic                       m_clipped;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_W-1:0]           cfg_wdata;

    int src_idle_pct = 0;
    int dst_idle_pct = 0;
    int mismatches;
    int words_pending;
    int stall_cycles = 0;

    // 100 MHz clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    multitap_feedback_reverb_core DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .m_clipped    (m_clipped),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    reverb_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_in   (s_sample_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sample_out  (m_sample_out),
        .m_clipped     (m_clipped),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .words_pending (words_pending)
    );

    // Randomize backpressure on the result channel
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // Abort when no word moves on either channel for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Present one sample, with an optional random gap first, and hold it until accepted
    task automatic send_word(input logic signed [SAMPLE_W-1:0] v);
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid     <= 1'b1;
        s_sample_in <= v;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and wait until every predicted word has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (words_pending != 0) @(posedge aclk);
        repeat (WORD_LATENCY + 4) @(posedge aclk);
    endtask

    function automatic logic [CFG_W-1:0] rand_tap_word(tap_plan_t plan);
        logic [DELAY_W-1:0] dly;
        logic [GAIN_W-1:0]  gain;
        int                 pick;
        pick = $urandom_range(9);
        if (pick == 9) begin
            return CFG_W'($urandom);
        end
        if (plan == TAPS_EXTREME) begin
            case ($urandom_range(3))
                0: dly = '0;
                1: dly = DELAY_W'(1);
                2: dly = DELAY_W'($urandom_range(2, 8));
                default: dly = DELAY_MAX;
            endcase
            case ($urandom_range(3))
                0: gain = GAIN_POS1;
                1: gain = GAIN_NEG1;
                2: gain = '1;
                default: gain = GAIN_W'(1);
            endcase
        end else begin
            // mostly short echoes that land on written samples
            if (pick < 2) begin
                dly = '0;
            end else if (pick < 7) begin
                dly = DELAY_W'($urandom_range(1, 40));
            end else if (pick < 8) begin
                dly = DELAY_W'($urandom_range(1, 900));
            end else begin
                dly = DELAY_W'($urandom);
            end
            // small gains keep the feedback mostly out of saturation
            if ($urandom_range(3) != 0) begin
                gain = GAIN_W'($urandom_range(10240) - 5120);
            end else begin
                gain = GAIN_W'($urandom);
            end
        end
        return {dly, gain};
    endfunction

    // Write all eight tap registers
    task automatic program_taps(tap_plan_t plan);
        logic [CFG_W-1:0] word;
        for (int i = 0; i < NUM_TAP_REGS; i++) begin
            if (plan == TAPS_DIRECTED) begin
                case (i)
                    0: word = {DELAY_W'(1), GAIN_POS1};
                    1: word = {DELAY_W'(2), GAIN_NEG1};
                    2: word = {DELAY_MAX, GAIN_W'(16'h4000)};
                    3: word = {DELAY_W'(3), GAIN_W'(16'h2000)};
                    // nonzero gain with zero delay must stay silent
                    default: word = {DELAY_W'(0), GAIN_POS1};
                endcase
            end else begin
                word = rand_tap_word(plan);
            end
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_wdata <= word;
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2, 3: return SAMPLE_W'($urandom_range(512) - 256);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    initial begin
        int seg;
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_sample_in <= '0;
        cfg_we      <= 1'b0;
        cfg_index   <= '0;
        cfg_wdata   <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // all taps off after reset: words pass straight through
        send_word(SAMPLE_MAX);
        send_word(SAMPLE_MIN);
        send_word('0);
        send_word(-16'sd1);
        send_word(16'sd1);
        wait_drained();

        // drive into both rails through the short taps, then let it ring out
        program_taps(TAPS_DIRECTED);
        repeat (3) send_word(SAMPLE_MAX);
        repeat (3) send_word(SAMPLE_MIN);
        repeat (3) send_word('0);
        send_word(16'sd1);
        send_word(-16'sd1);
        send_word(16'sd12345);
        wait_drained();

        // random segments: sender light/receiver heavy, swapped, then none
        for (seg = 0; seg < SEG_COUNT; seg++) begin
            src_idle_pct = (seg < 2) ? 19 : (seg < 4) ? 86 : 0;
            dst_idle_pct = (seg < 2) ? 86 : (seg < 4) ? 19 : 0;
            program_taps((seg == 3) ? TAPS_EXTREME : TAPS_TYPICAL);
            repeat (SEG_WORDS) send_word(rand_sample());
            wait_drained();
        end

        if (mismatches == 0 && words_pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
